// ===== rtl/pdos_pkg.sv =====
// Shared types, constants and a function of the protected-DOS sector decrypt block.
package pdos_pkg;

   localparam int unsigned WordsPerSectorDefault = 128;
   localparam int unsigned CsrAddrWidth          = 4;

   localparam logic [31:0] HeaderFlagMask = 32'h8000_0000;
   localparam logic [31:0] ChecksumMask   = 32'h5555_5555;

   typedef enum logic [1:0] {
      CMD_SYNC   = 2'd0,
      CMD_HEADER = 2'd1,
      CMD_DATA   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_DISK_KEY    = 2'd0,
      REG_TRACK       = 2'd1,
      REG_SECTORS     = 2'd2,
      REG_CHECK_HDR   = 2'd3
   } reg_index_type;

   localparam logic [3:0] SectorsResetValue = 4'd12;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] word;
   } req_type;

   typedef struct packed {
      logic [31:0] plain_word;
      logic [6:0]  word_index;
      logic [3:0]  sector_number;
      logic        last;
      logic        sector_ok;
      logic [31:0] derived_key;
      logic        track_done;
   } rsp_type;

   typedef struct packed {
      logic [31:0] disk_key;
      logic [7:0]  track_number;
      logic [3:0]  sectors_per_track;
      logic        check_header;
   } cfg_type;

   // Folds a 32-bit XOR sum of the encrypted longs to the 16-bit disk checksum.
   function automatic logic [15:0] fold_checksum(input logic [31:0] acc);
      logic [31:0] c;
      logic [31:0] f;
      c = (acc ^ (acc >> 1)) & ChecksumMask;
      f = c | (c >> 15);
      return f[15:0];
   endfunction

endpackage

// ===== rtl/pdos_csr.sv =====
// Configuration registers of the protected-DOS sector decrypt block, on an APB-style port.
module pdos_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pdos_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output pdos_pkg::cfg_type                   cfg
);

   pdos_pkg::cfg_type cfg_ff, cfg_in;
   pdos_pkg::reg_index_type index;
   logic write_strobe;

   assign index        = pdos_pkg::reg_index_type'(paddr[3:2]);
   assign write_strobe = psel && penable && pwrite;
   assign pready       = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (index)
            pdos_pkg::REG_DISK_KEY:  cfg_in.disk_key          = pwdata;
            pdos_pkg::REG_TRACK:     cfg_in.track_number      = pwdata[7:0];
            pdos_pkg::REG_SECTORS:   cfg_in.sectors_per_track = pwdata[3:0];
            pdos_pkg::REG_CHECK_HDR: cfg_in.check_header      = pwdata[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         pdos_pkg::REG_DISK_KEY:  prdata = cfg_ff.disk_key;
         pdos_pkg::REG_TRACK:     prdata = {24'd0, cfg_ff.track_number};
         pdos_pkg::REG_SECTORS:   prdata = {28'd0, cfg_ff.sectors_per_track};
         pdos_pkg::REG_CHECK_HDR: prdata = {31'd0, cfg_ff.check_header};
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.disk_key          <= 32'd0;
         cfg_ff.track_number      <= 8'd0;
         cfg_ff.sectors_per_track <= pdos_pkg::SectorsResetValue;
         cfg_ff.check_header      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/pdos_sector_decrypt_verify.sv =====
// Top level of the protected-DOS sector decrypt and verify block.
//
// Usage: the req channel carries decoded 32-bit longs of one track, each with a
// command: track sync, sector header long, or encrypted data long. Sync and
// header transfers update the sector state and produce no result. Each data
// transfer produces exactly one rsp transfer carrying the decrypted long, its
// position in the sector and sector index; on the final long of a sector the
// result also carries the header check, the key implied by the header and the
// track-complete flag.
// A data long accepted at one edge is offered on rsp from the next cycle.
// Throughput is one long per cycle, set by the single chain/checksum state
// update done in the accepting cycle, and held while the receiver keeps
// taking results. The result register lets a new long be accepted in the
// same cycle as the waiting result is taken; req_stall is raised only while
// a result waits and rsp_stall is high. The user must write the configuration
// port only while the block is idle; the block does not enforce this.
// Reset (synchronous) empties the result register, clears the sector state,
// sets the track-good flag and loads the register reset values.
module pdos_sector_decrypt_verify #(
   parameter int unsigned WORDS_PER_SECTOR = pdos_pkg::WordsPerSectorDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pdos_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pdos_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pdos_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam logic [6:0] LastIndex = 7'(WORDS_PER_SECTOR - 1);

   pdos_pkg::cfg_type cfg;

   pdos_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sector state.
   logic [31:0] header_hold_ff,  header_hold_in;
   logic [31:0] chain_value_ff,  chain_value_in;
   logic [31:0] checksum_acc_ff, checksum_acc_in;
   logic [6:0]  word_count_ff,   word_count_in;
   logic [3:0]  sector_count_ff, sector_count_in;
   logic        track_good_ff,   track_good_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   pdos_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   logic              accept;
   pdos_pkg::cmd_type cmd;
   logic [31:0]       acc_next;
   logic [15:0]       csum;
   logic [31:0]       expected;
   logic              is_last;
   logic              ok;
   logic              good_next;
   logic [4:0]        sector_plus_one;

   // A new transfer is taken whenever the result register is empty or is
   // being emptied in this cycle.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cmd             = pdos_pkg::cmd_type'(req_data.cmd);
   assign acc_next        = checksum_acc_ff ^ req_data.word;
   assign csum            = pdos_pkg::fold_checksum(acc_next);
   assign expected        = {4'd0, sector_count_ff, cfg.track_number, csum};
   assign is_last         = word_count_ff >= LastIndex;
   assign ok              = cfg.check_header
                            ? ((header_hold_ff ^ cfg.disk_key ^ pdos_pkg::HeaderFlagMask)
                               == expected)
                            : 1'b1;
   assign good_next       = track_good_ff && ok;
   assign sector_plus_one = {1'b0, sector_count_ff} + 5'd1;

   always_comb begin
      header_hold_in  = header_hold_ff;
      chain_value_in  = chain_value_ff;
      checksum_acc_in = checksum_acc_ff;
      word_count_in   = word_count_ff;
      sector_count_in = sector_count_ff;
      track_good_in   = track_good_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_data_in     = rsp_data_ff;

      if (accept) begin
         unique case (cmd)
            pdos_pkg::CMD_SYNC: begin
               sector_count_in = 4'd0;
               word_count_in   = 7'd0;
               checksum_acc_in = 32'd0;
               track_good_in   = 1'b1;
            end
            pdos_pkg::CMD_HEADER: begin
               header_hold_in  = req_data.word;
               chain_value_in  = cfg.disk_key;
               checksum_acc_in = 32'd0;
               word_count_in   = 7'd0;
            end
            pdos_pkg::CMD_DATA: begin
               chain_value_in  = req_data.word;
               checksum_acc_in = acc_next;
               rsp_valid_in    = 1'b1;

               rsp_data_in.plain_word    = req_data.word ^ chain_value_ff;
               rsp_data_in.word_index    = word_count_ff;
               rsp_data_in.sector_number = sector_count_ff;
               rsp_data_in.last          = is_last;
               rsp_data_in.sector_ok     = 1'b0;
               rsp_data_in.derived_key   = 32'd0;
               rsp_data_in.track_done    = 1'b0;

               if (is_last) begin
                  rsp_data_in.sector_ok   = ok;
                  // The key implied by the header, with the flag bit clear.
                  rsp_data_in.derived_key =
                     {1'b0,
                      header_hold_ff[30:24] ^ {3'd0, sector_count_ff},
                      header_hold_ff[23:16] ^ cfg.track_number,
                      header_hold_ff[15:0] ^ csum};
                  rsp_data_in.track_done  =
                     good_next && (sector_plus_one == {1'b0, cfg.sectors_per_track});
                  track_good_in   = good_next;
                  sector_count_in = sector_plus_one[3:0];
                  word_count_in   = 7'd0;
               end else begin
                  word_count_in = word_count_ff + 7'd1;
               end
            end
            pdos_pkg::CMD_NONE: begin
               // Unused command: no state change and no result.
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_hold_ff  <= 32'd0;
         chain_value_ff  <= 32'd0;
         checksum_acc_ff <= 32'd0;
         word_count_ff   <= 7'd0;
         sector_count_ff <= 4'd0;
         track_good_ff   <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         header_hold_ff  <= header_hold_in;
         chain_value_ff  <= chain_value_in;
         checksum_acc_ff <= checksum_acc_in;
         word_count_ff   <= word_count_in;
         sector_count_ff <= sector_count_in;
         track_good_ff   <= track_good_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the protected-DOS sector decrypt and verify block.
`timescale 1ns / 100ps

module tb_top;

   // The block is built with full-size sectors, as it is used on real disks.
   localparam int SectorLongs   = 128;
   // Each side idles in roughly this share of cycles outside the steady stretch.
   localparam int IdlePercent   = 38;
   // Length of the long receiver hold-off that fills the block up.
   localparam int HoldOffCycles = 300;
   // Cycles left after the last result before a register write or the verdict.
   // Sync and header transfers give no result, so this covers their state update.
   localparam int SettleCycles  = 6;
   localparam int DrainLimit    = 5000;
   localparam int ReportLimit   = 10;

   // Ways in which a generated sector departs from a clean one.
   typedef enum int {
      FLAW_NONE,
      FLAW_HEADER_BIT,
      FLAW_WRONG_SECTOR,
      FLAW_TRUNCATED,
      FLAW_NO_HEADER,
      FLAW_NOISE
   } sector_flaw_type;

   // Folds the XOR sum of the encrypted longs of a sector to its 16-bit checksum:
   // adjacent bits are combined, the even positions are kept and the two halves merged.
   function automatic logic [15:0] disk_checksum16(input logic [31:0] xor_sum);
      logic [31:0] mixed;
      mixed = (xor_sum ^ {1'b0, xor_sum[31:1]}) & pdos_pkg::ChecksumMask;
      return mixed[15:0] | mixed[30:15];
   endfunction

   // Predicts the decrypted longs and the per-sector verdicts, and checks the
   // results that the block hands over against them in order.
   class sector_scoreboard;
      pdos_pkg::cfg_type regs;
      logic [31:0]       header_word;
      logic [31:0]       prev_cipher;
      logic [31:0]       cipher_xor;
      logic [6:0]        long_index;
      logic [3:0]        sector_index;
      logic              all_good;
      pdos_pkg::rsp_type expected_longs[$];
      int                error_count;

      function new();
         regs = '{disk_key: '0, track_number: '0,
                  sectors_per_track: pdos_pkg::SectorsResetValue, check_header: 1'b1};
         header_word  = '0;
         prev_cipher  = '0;
         cipher_xor   = '0;
         long_index   = '0;
         sector_index = '0;
         all_good     = 1'b1;
         error_count  = 0;
      endfunction

      function void write_reg(pdos_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            pdos_pkg::REG_DISK_KEY:  regs.disk_key          = value;
            pdos_pkg::REG_TRACK:     regs.track_number      = value[7:0];
            pdos_pkg::REG_SECTORS:   regs.sectors_per_track = value[3:0];
            pdos_pkg::REG_CHECK_HDR: regs.check_header      = value[0];
            default: ;
         endcase
      endfunction

      // Called for every accepted input transfer; data longs queue one result.
      function void note_request(pdos_pkg::req_type item);
         pdos_pkg::rsp_type predicted;
         logic [15:0]       csum;
         logic [31:0]       sector_word;
         case (pdos_pkg::cmd_type'(item.cmd))
            pdos_pkg::CMD_SYNC: begin
               sector_index = '0;
               long_index   = '0;
               cipher_xor   = '0;
               all_good     = 1'b1;
            end
            pdos_pkg::CMD_HEADER: begin
               header_word = item.word;
               prev_cipher = regs.disk_key;
               cipher_xor  = '0;
               long_index  = '0;
            end
            pdos_pkg::CMD_DATA: begin
               predicted               = '0;
               predicted.plain_word    = item.word ^ prev_cipher;
               predicted.word_index    = long_index;
               predicted.sector_number = sector_index;
               predicted.last          = (int'(long_index) >= SectorLongs - 1);
               prev_cipher = item.word;
               cipher_xor  = cipher_xor ^ item.word;
               if (predicted.last) begin
                  csum        = disk_checksum16(cipher_xor);
                  sector_word = {4'h0, sector_index, regs.track_number, csum};
                  predicted.sector_ok = !regs.check_header ||
                     ((header_word ^ regs.disk_key ^ pdos_pkg::HeaderFlagMask) == sector_word);
                  predicted.derived_key = {1'b0,
                                           header_word[30:24] ^ {3'b000, sector_index},
                                           header_word[23:16] ^ regs.track_number,
                                           header_word[15:0] ^ csum};
                  all_good = all_good & predicted.sector_ok;
                  predicted.track_done = all_good &&
                     (int'(sector_index) + 1 == int'(regs.sectors_per_track));
                  sector_index++;
                  long_index = '0;
               end else begin
                  long_index++;
               end
               expected_longs.push_back(predicted);
            end
            default: ;
         endcase
      endfunction

      function bit field_differs(string name, logic [31:0] want, logic [31:0] got, bit show);
         if (got === want) return 1'b0;
         if (show) $display("ERROR %0t: %s expected %h got %h", $time, name, want, got);
         return 1'b1;
      endfunction

      // Called for every accepted result transfer.
      function void check_response(pdos_pkg::rsp_type got);
         pdos_pkg::rsp_type want;
         bit                show;
         bit                bad;
         show = error_count < ReportLimit;
         if (expected_longs.size() == 0) begin
            if (show) $display("ERROR %0t: unexpected result, plain_word %h", $time,
                               got.plain_word);
            error_count++;
            return;
         end
         want = expected_longs.pop_front();
         bad  = 1'b0;
         bad |= field_differs("plain_word", want.plain_word, got.plain_word, show);
         bad |= field_differs("word_index", 32'(want.word_index), 32'(got.word_index),
                              show);
         bad |= field_differs("sector_number", 32'(want.sector_number),
                              32'(got.sector_number), show);
         bad |= field_differs("last", 32'(want.last), 32'(got.last), show);
         bad |= field_differs("sector_ok", 32'(want.sector_ok), 32'(got.sector_ok), show);
         bad |= field_differs("derived_key", want.derived_key, got.derived_key, show);
         bad |= field_differs("track_done", 32'(want.track_done), 32'(got.track_done),
                              show);
         if (bad) error_count++;
      endfunction

      function bit run_clean();
         if (expected_longs.size() != 0) begin
            $display("ERROR: %0d expected results never arrived", expected_longs.size());
            error_count++;
         end
         return error_count == 0;
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   pdos_pkg::req_type                 req_data;
   logic                              rsp_valid;
   logic                              rsp_stall;
   pdos_pkg::rsp_type                 rsp_data;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [pdos_pkg::CsrAddrWidth-1:0] paddr;
   logic [31:0]                       pwdata;
   logic [31:0]                       prdata;
   logic                              pready;

   sector_scoreboard sb = new();

   // Register values as last written, used to build headers that should pass.
   pdos_pkg::cfg_type written_cfg;
   // Sector number the next clean header should carry.
   logic [3:0]        sector_cursor;
   // While set, neither side idles.
   bit                steady;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit                hold_off_request;

   always #1 clock = ~clock;

   pdos_sector_decrypt_verify #(
      .WORDS_PER_SECTOR(SectorLongs)
   ) u_top (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .psel,
      .penable,
      .pwrite,
      .paddr,
      .pwdata,
      .prdata,
      .pready
   );

   // Both channels are observed at the rising edge, where a transfer completes
   // if valid is high and stall is low. Results are checked before the new input
   // is noted, although a result can never belong to the input of the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
      end
   end

   // Receiver: stalls at random, not at all during the steady stretch, and once
   // holds off for a long count of its own so that the result register stays
   // full and the block has to stall its input.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HoldOffCycles;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IdlePercent);
         end
      end
   end

   // Offers one long, after a random number of idle cycles, and returns at the
   // edge at which the transfer completes. The payload is held while stalled.
   task automatic send_long(pdos_pkg::cmd_type op, logic [31:0] value);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{cmd: op, word: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drops valid, waits for every outstanding result and then a few more cycles
   // so that a trailing sync or header transfer has also been absorbed.
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_longs.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register is written at the edge that
   // closes the access. psel drops for a cycle before the next write.
   task automatic csr_write(pdos_pkg::reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, value);
      @(posedge clock);
   endtask

   // Registers are only written once the block has gone idle.
   task automatic configure(logic [31:0] key, logic [7:0] track, logic [3:0] sectors,
                            logic check);
      wait_drained();
      csr_write(pdos_pkg::REG_DISK_KEY, key);
      csr_write(pdos_pkg::REG_TRACK, {24'h0, track});
      csr_write(pdos_pkg::REG_SECTORS, {28'h0, sectors});
      csr_write(pdos_pkg::REG_CHECK_HDR, {31'h0, check});
      written_cfg = '{disk_key: key, track_number: track,
                      sectors_per_track: sectors, check_header: check};
   endtask

   // Encrypted longs lean towards all zeros and all ones now and then.
   function automatic logic [31:0] pick_cipher_long();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Sends one sector: a header built to match the encrypted data that follows,
   // unless the chosen flaw spoils the header, drops it, cuts the data short or
   // sprinkles ignored commands among the data.
   task automatic send_sector(sector_flaw_type flaw);
      logic [31:0] cipher [SectorLongs];
      logic [31:0] xor_sum;
      logic [31:0] header;
      int          count;
      xor_sum = '0;
      for (int i = 0; i < SectorLongs; i++) begin
         cipher[i] = pick_cipher_long();
         xor_sum   = xor_sum ^ cipher[i];
      end
      header = written_cfg.disk_key ^ pdos_pkg::HeaderFlagMask ^
               {4'h0, sector_cursor, written_cfg.track_number, disk_checksum16(xor_sum)};
      count  = SectorLongs;
      case (flaw)
         FLAW_HEADER_BIT:   header = header ^ (32'h1 << $urandom_range(31));
         FLAW_WRONG_SECTOR: header = header ^ (32'($urandom_range(1, 15)) << 24);
         FLAW_TRUNCATED:    count  = $urandom_range(1, SectorLongs - 1);
         default: ;
      endcase
      if (flaw != FLAW_NO_HEADER) send_long(pdos_pkg::CMD_HEADER, header);
      for (int i = 0; i < count; i++) begin
         if (flaw == FLAW_NOISE && $urandom_range(15) == 0)
            send_long(pdos_pkg::CMD_NONE, $urandom);
         send_long(pdos_pkg::CMD_DATA, cipher[i]);
      end
      if (count == SectorLongs) sector_cursor++;
   endtask

   // A track: a sync, then the given number of sectors, a share of them flawed.
   task automatic send_track(int sectors, int flaw_percent);
      send_long(pdos_pkg::CMD_SYNC, $urandom);
      sector_cursor = '0;
      for (int s = 0; s < sectors; s++) begin
         if ($urandom_range(99) < flaw_percent)
            send_sector(sector_flaw_type'($urandom_range(int'(FLAW_HEADER_BIT),
                                                          int'(FLAW_NOISE))));
         else
            send_sector(FLAW_NONE);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      steady           = 1'b0;
      hold_off_request = 1'b0;
      sector_cursor    = '0;
      written_cfg      = '{disk_key: '0, track_number: '0,
                           sectors_per_track: pdos_pkg::SectorsResetValue,
                           check_header: 1'b1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset register values. Data arrives before any
      // header, the ignored command and sync carry extreme words, a header is
      // cut short by a second header, and a sync lands in the middle of a sector.
      send_long(pdos_pkg::CMD_DATA, 32'hffff_ffff);
      send_long(pdos_pkg::CMD_DATA, 32'h0000_0000);
      send_long(pdos_pkg::CMD_NONE, 32'hffff_ffff);
      send_long(pdos_pkg::CMD_SYNC, 32'hffff_ffff);
      send_long(pdos_pkg::CMD_HEADER, 32'h8000_0000);
      send_long(pdos_pkg::CMD_DATA, 32'h1234_5678);
      send_long(pdos_pkg::CMD_DATA, 32'ha5a5_a5a5);
      send_long(pdos_pkg::CMD_DATA, 32'h0000_0000);
      send_long(pdos_pkg::CMD_NONE, 32'h0000_0000);
      send_long(pdos_pkg::CMD_HEADER, 32'h0000_0000);
      send_long(pdos_pkg::CMD_DATA, 32'hffff_ffff);
      send_long(pdos_pkg::CMD_DATA, 32'h5a5a_5a5a);
      send_long(pdos_pkg::CMD_SYNC, 32'h0000_0000);
      send_long(pdos_pkg::CMD_DATA, 32'h8000_0001);
      send_long(pdos_pkg::CMD_HEADER, 32'hffff_ffff);
      send_long(pdos_pkg::CMD_DATA, 32'h7fff_fffe);

      // A clean two-sector track with a random key. The receiver holds off early
      // on while the sender keeps offering, so the block fills up and stalls its
      // input.
      configure($urandom, 8'($urandom_range(159)), 4'd2, 1'b1);
      hold_off_request = 1'b1;
      send_track(2, 0);

      // Extreme key and track number with the most sectors per track, and no
      // idling on either side.
      configure(32'hffff_ffff, 8'hff, 4'd15, 1'b1);
      steady = 1'b1;
      send_track(1, 0);
      steady = 1'b0;

      // Derive mode with a zero key and no sectors per track: every sector is
      // reported good but the track is never complete.
      configure(32'h0000_0000, 8'h00, 4'd0, 1'b0);
      send_track(1, 50);

      // One-sector tracks, so every clean sector completes its track, with a
      // pause for all results between them.
      configure($urandom, 8'($urandom_range(255)), 4'd1, 1'b1);
      send_track(1, 50);
      wait_drained();
      send_track(1, 50);

      wait_drained();
      if (sb.run_clean())
         $display("pdos_sector_decrypt_verify test passed");
      else
         $display("pdos_sector_decrypt_verify test failed");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("pdos_sector_decrypt_verify test failed");
      $finish;
   end

endmodule
